@@ hdl/bpcfm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcfm_pkg
// shared constants, status codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package bpcfm_pkg;

  localparam int FRAMES_DEF       = 64;
  localparam int PIN_BITS_DEF     = 8;
  localparam int PAGE_ID_BITS_DEF = 48;

  localparam int PAGE_W    = 48;
  localparam int FRAME_W   = 6;
  localparam int CFG_W     = 7;
  localparam int STATUS_W  = 3;
  localparam int CNT_W     = 32;

  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FREE     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EVICT    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNPINNED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd5;

  // commands from controller to datapath
  typedef struct packed {
    logic load_req;    // capture input beat
    logic scan_start;  // reset scan pointer
    logic scan_step;   // read one frame, advance pointer
    logic unpin_rd;    // read pin and mark of the unpin frame
    logic sweep_init;  // wrap hand, record start
    logic sweep_rd;    // read frame at hand
    logic sweep_step;  // mark frame at hand if unpinned, advance hand
    logic do_unpin;    // finish unpin
    logic do_hit;      // finish hit
    logic do_free;     // finish free-frame fill
    logic do_evict;    // finish eviction
    logic do_none;     // finish with no frame
  } bpcfm_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_unpin;
    logic scan_hit;    // frame read by the scan matches
    logic scan_done;   // pointer reached filled count
    logic free_avail;  // filled below usable count
    logic sweep_found; // unpinned marked frame read at hand
    logic sweep_end;   // two turns done and back at start
    logic out_busy;    // output register holds an untaken beat
  } bpcfm_sts_t;

endpackage

@@ hdl/buffer_pool_clock_frame_manager.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_pool_clock_frame_manager
// page-frame manager with pin counts and clock replacement
// ----------------------------------------------------------------------------
// One request is handled at a time. A pin request scans the filled frames one
// per cycle through the page store read port. A miss that must sweep reads,
// then examines, each frame visited by the hand, up to two turns of the
// usable frames, and a sweep that finds nothing closes with no frame. Unpin
// reads the pin and mark of its frame, then finishes. The result sits in an
// output register; a new request is taken once the previous one has been
// written there.
module buffer_pool_clock_frame_manager #(
  parameter int FRAMES       = bpcfm_pkg::FRAMES_DEF,
  parameter int PIN_BITS     = bpcfm_pkg::PIN_BITS_DEF,
  parameter int PAGE_ID_BITS = bpcfm_pkg::PAGE_ID_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bpcfm_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [bpcfm_pkg::PAGE_W-1:0]   in_page_id,
  input  logic [bpcfm_pkg::FRAME_W-1:0]  in_unpin_frame,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bpcfm_pkg::FRAME_W-1:0]  out_frame,
  output logic [bpcfm_pkg::STATUS_W-1:0] out_status,
  output logic                           out_load_needed,
  output logic [bpcfm_pkg::PAGE_W-1:0]   out_evicted_page,
  output logic [bpcfm_pkg::CNT_W-1:0]    out_miss_count,
  output logic [bpcfm_pkg::CNT_W-1:0]    out_request_count
);
  import bpcfm_pkg::*;

  bpcfm_cmd_t cmd;
  bpcfm_sts_t sts;

  // sequencer
  bpcfm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // tables and result path
  bpcfm_datapath #(
    .FRAMES       (FRAMES),
    .PIN_BITS     (PIN_BITS),
    .PAGE_ID_BITS (PAGE_ID_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_kind           (in_kind),
    .in_page_id        (in_page_id),
    .in_unpin_frame    (in_unpin_frame),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame         (out_frame),
    .out_status        (out_status),
    .out_load_needed   (out_load_needed),
    .out_evicted_page  (out_evicted_page),
    .out_miss_count    (out_miss_count),
    .out_request_count (out_request_count)
  );

endmodule

@@ hdl/bpcfm_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcfm_datapath
// frame tables, scan and sweep pointers, counters and the output register
// ----------------------------------------------------------------------------
module bpcfm_datapath #(
  parameter int FRAMES       = bpcfm_pkg::FRAMES_DEF,
  parameter int PIN_BITS     = bpcfm_pkg::PIN_BITS_DEF,
  parameter int PAGE_ID_BITS = bpcfm_pkg::PAGE_ID_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bpcfm_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                                in_kind,
  input  logic [bpcfm_pkg::PAGE_W-1:0]        in_page_id,
  input  logic [bpcfm_pkg::FRAME_W-1:0]       in_unpin_frame,
  input  bpcfm_pkg::bpcfm_cmd_t               cmd,
  output bpcfm_pkg::bpcfm_sts_t               sts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bpcfm_pkg::FRAME_W-1:0]       out_frame,
  output logic [bpcfm_pkg::STATUS_W-1:0]      out_status,
  output logic                                out_load_needed,
  output logic [bpcfm_pkg::PAGE_W-1:0]        out_evicted_page,
  output logic [bpcfm_pkg::CNT_W-1:0]         out_miss_count,
  output logic [bpcfm_pkg::CNT_W-1:0]         out_request_count
);
  import bpcfm_pkg::*;

  localparam int IW  = $clog2(FRAMES);
  localparam int CW  = $clog2(FRAMES + 1);
  localparam int PMW = PIN_BITS + 1;
  localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

  // page store and {mark, pin count} store, both read through registers;
  // entries at or above the filled count never affect a result
  logic [PAGE_ID_BITS-1:0] page_mem [FRAMES];
  logic [PAGE_ID_BITS-1:0] rd_page_r;
  logic [PMW-1:0]          pm_mem [FRAMES];
  logic [PMW-1:0]          rd_pm_r;

  logic [CFG_W-1:0]        cfg_r;
  logic [CW-1:0]           filled_r;
  logic [IW-1:0]           hand_r;
  logic [IW-1:0]           start_r;
  logic [1:0]              turns_r;   // passes over the start frame
  logic [CW-1:0]           scan_r;
  logic                    scan_v_r;  // read registers hold entry scan_r-1
  logic [CNT_W-1:0]        miss_r;
  logic [CNT_W-1:0]        req_r;

  logic                    kind_r;
  logic [PAGE_ID_BITS-1:0] pid_r;
  logic [FRAME_W-1:0]      uf_r;

  logic                    ov_r;
  logic [FRAME_W-1:0]      of_r;
  logic [STATUS_W-1:0]     os_r;
  logic                    ol_r;
  logic [PAGE_W-1:0]       oe_r;
  logic [CNT_W-1:0]        om_r;
  logic [CNT_W-1:0]        oq_r;

  // usable frame count, clamped into 1..FRAMES
  logic [CW-1:0] cap;
  always_comb begin
    if (cfg_r == '0) cap = CW'(1);
    else if (32'(cfg_r) > FRAMES) cap = CW'(FRAMES);
    else cap = CW'(cfg_r);
  end

  logic [IW-1:0] hand_next;
  assign hand_next = (32'(hand_r) + 1 >= 32'(cap)) ? '0 : hand_r + IW'(1);

  logic [PIN_BITS-1:0] rd_pin;
  logic                rd_mark;
  assign rd_pin  = rd_pm_r[PIN_BITS-1:0];
  assign rd_mark = rd_pm_r[PIN_BITS];

  logic [IW-1:0] uf_idx;
  assign uf_idx = IW'(uf_r);
  logic unpin_ok;
  assign unpin_ok = (32'(uf_r) < 32'(filled_r)) && (32'(uf_r) < FRAMES)
                    && (rd_pin != '0);

  logic [IW-1:0] hit_idx;
  assign hit_idx = IW'(scan_r - CW'(1));

  logic finish;
  assign finish = cmd.do_unpin | cmd.do_hit | cmd.do_free | cmd.do_evict | cmd.do_none;

  // status toward the controller
  always_comb begin
    sts.is_unpin    = kind_r;
    sts.scan_hit    = scan_v_r && (rd_page_r == pid_r);
    sts.scan_done   = (scan_r >= filled_r);
    sts.free_avail  = (filled_r < cap);
    sts.sweep_found = (rd_pin == '0) && rd_mark;
    sts.sweep_end   = (turns_r == 2'd2) && (hand_r == start_r);
  end
  assign sts.out_busy = ov_r && out_stall;

  // read address select
  logic          rd_en;
  logic [IW-1:0] rd_idx;
  always_comb begin
    rd_en = cmd.scan_step | cmd.unpin_rd | cmd.sweep_rd;
    if (cmd.sweep_rd) rd_idx = hand_r;
    else if (cmd.unpin_rd) rd_idx = uf_idx;
    else rd_idx = IW'(scan_r);
  end

  // pin and mark write-back
  logic           pm_we;
  logic [IW-1:0]  wr_idx;
  logic [PMW-1:0] pm_wdata;
  always_comb begin
    pm_we    = 1'b0;
    wr_idx   = hand_r;
    pm_wdata = {1'b0, PIN_BITS'(1)};
    if (cmd.do_unpin) begin
      pm_we    = unpin_ok;
      wr_idx   = uf_idx;
      pm_wdata = {rd_mark, rd_pin - PIN_BITS'(1)};
    end else if (cmd.do_hit) begin
      pm_we    = 1'b1;
      wr_idx   = hit_idx;
      pm_wdata = {1'b0, (rd_pin == PIN_MAX) ? rd_pin : rd_pin + PIN_BITS'(1)};
    end else if (cmd.do_free) begin
      pm_we  = 1'b1;
      wr_idx = IW'(filled_r);
    end else if (cmd.do_evict) begin
      pm_we  = 1'b1;
      wr_idx = hand_r;
    end else if (cmd.sweep_step) begin
      pm_we    = (rd_pin == '0);
      wr_idx   = hand_r;
      pm_wdata = {1'b1, rd_pin};
    end
  end

  // frame stores, registered read
  always_ff @(posedge clk) begin
    if (cmd.do_free) page_mem[IW'(filled_r)] <= pid_r;
    else if (cmd.do_evict) page_mem[hand_r] <= pid_r;
    if (pm_we) pm_mem[wr_idx] <= pm_wdata;
    if (rd_en) begin
      rd_page_r <= page_mem[rd_idx];
      rd_pm_r   <= pm_mem[rd_idx];
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind_r <= in_kind;
      pid_r  <= PAGE_ID_BITS'(in_page_id);
      uf_r   <= in_unpin_frame;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r    <= CFG_W'(64);
      filled_r <= '0;
      hand_r   <= '0;
      start_r  <= '0;
      turns_r  <= '0;
      scan_r   <= '0;
      scan_v_r <= 1'b0;
      miss_r   <= '0;
      req_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      if (cfg_we) cfg_r <= cfg_wdata;
      if (ov_r && !out_stall) ov_r <= 1'b0;

      // scan pointer walks the filled frames
      if (cmd.scan_start) begin
        scan_r   <= '0;
        scan_v_r <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_r   <= scan_r + CW'(1);
        scan_v_r <= 1'b1;
      end

      // sweep hand
      if (cmd.sweep_init) begin
        if (32'(hand_r) >= 32'(cap)) begin
          hand_r  <= '0;
          start_r <= '0;
        end else start_r <= hand_r;
        turns_r <= '0;
      end else if (cmd.sweep_step) begin
        if (hand_r == start_r) turns_r <= turns_r + 2'd1;
        hand_r <= hand_next;
      end

      if (cmd.load_req && !in_kind) req_r <= req_r + CNT_W'(1);

      // finishing actions
      if (cmd.do_free) filled_r <= filled_r + CW'(1);
      if (cmd.do_free || cmd.do_evict) miss_r <= miss_r + CNT_W'(1);
      if (finish) ov_r <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.do_unpin) begin
      of_r <= uf_r;
      os_r <= unpin_ok ? ST_UNPINNED : ST_IGNORED;
      ol_r <= 1'b0;
      oe_r <= '0;
    end else if (cmd.do_hit) begin
      of_r <= FRAME_W'(hit_idx);
      os_r <= ST_HIT;
      ol_r <= 1'b0;
      oe_r <= '0;
    end else if (cmd.do_free) begin
      of_r <= FRAME_W'(filled_r);
      os_r <= ST_FREE;
      ol_r <= 1'b1;
      oe_r <= '0;
    end else if (cmd.do_evict) begin
      of_r <= FRAME_W'(hand_r);
      os_r <= ST_EVICT;
      ol_r <= 1'b1;
      oe_r <= PAGE_W'(rd_page_r);
    end else if (cmd.do_none) begin
      of_r <= '0;
      os_r <= ST_NONE;
      ol_r <= 1'b0;
      oe_r <= '0;
    end
    // counters as seen right after this request
    if (finish) begin
      om_r <= (cmd.do_free || cmd.do_evict) ? miss_r + CNT_W'(1) : miss_r;
      oq_r <= req_r;
    end
  end

  assign out_valid         = ov_r;
  assign out_frame         = of_r;
  assign out_status        = os_r;
  assign out_load_needed   = ol_r;
  assign out_evicted_page  = oe_r;
  assign out_miss_count    = om_r;
  assign out_request_count = oq_r;

endmodule

@@ hdl/bpcfm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcfm_ctrl
// request sequencer: lookup scan, unpin, free fill, clock sweep, result hand-off
// ----------------------------------------------------------------------------
module bpcfm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bpcfm_pkg::bpcfm_sts_t sts,
  output bpcfm_pkg::bpcfm_cmd_t cmd
);
  import bpcfm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_MISS  = 6'b000100,
    S_SWEEP = 6'b001000,
    S_SWRD  = 6'b010000,
    S_UNPIN = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // a finish needs a free output register
  logic can_fin;
  assign can_fin = !sts.out_busy;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_req   = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.is_unpin) begin
          cmd.unpin_rd = 1'b1;
          state_nxt    = S_UNPIN;
        end else if (sts.scan_hit) begin
          if (can_fin) begin
            cmd.do_hit = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else if (sts.scan_done) state_nxt = S_MISS;
        else cmd.scan_step = 1'b1;
      end
      S_UNPIN: begin
        if (can_fin) begin
          cmd.do_unpin = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_MISS: begin
        if (sts.free_avail) begin
          if (can_fin) begin
            cmd.do_free = 1'b1;
            state_nxt   = S_IDLE;
          end
        end else begin
          cmd.sweep_init = 1'b1;
          state_nxt      = S_SWRD;
        end
      end
      S_SWRD: begin
        // stop after two turns, else read the frame at the hand
        if (sts.sweep_end) begin
          if (can_fin) begin
            cmd.do_none = 1'b1;
            state_nxt   = S_IDLE;
          end
        end else begin
          cmd.sweep_rd = 1'b1;
          state_nxt    = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (sts.sweep_found) begin
          if (can_fin) begin
            cmd.do_evict = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.sweep_step = 1'b1;
          state_nxt      = S_SWRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule
